@@ rtl/bitmap_query_unit_defines.svh @@
// assertion macros for the bitmap query unit
// used by files that assert; no other dependencies
`ifndef BITMAP_QUERY_UNIT_DEFINES_SVH
`define BITMAP_QUERY_UNIT_DEFINES_SVH

// checked at every clock edge, also during reset
`define BQU_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define BQU_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/bqu_pkg.sv @@
// shared types, operation codes and helper functions of the bitmap query unit
// no dependencies
package bqu_pkg;

   localparam int MAP_BITS = 64;

   typedef enum logic [3:0] {
      OP_NEXT      = 4'd0,
      OP_NEXT_AND  = 4'd1,
      OP_FIRST     = 4'd2,
      OP_FIRST_AND = 4'd3,
      OP_TEST      = 4'd4,
      OP_WEIGHT    = 4'd5,
      OP_AND       = 4'd6,
      OP_OR        = 4'd7,
      OP_EQUAL     = 4'd8,
      OP_SUBSET    = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0]          op;
      logic [MAP_BITS-1:0] first_map;
      logic [MAP_BITS-1:0] second_map;
      logic [5:0]          start_index;
   } req_beat_type;

   typedef struct packed {
      logic                found;
      logic [5:0]          found_index;
      logic [MAP_BITS-1:0] result_map;
      logic [6:0]          bit_count;
      logic                result_flag;
   } rsp_beat_type;

   // index of the lowest set bit, zero for an empty map
   function automatic logic [5:0] low_index(logic [MAP_BITS-1:0] v);
      logic [MAP_BITS-1:0] one_hot;
      logic [5:0]          idx;
      one_hot = v & (~v + MAP_BITS'(1));
      idx     = '0;
      for (int i = 0; i < MAP_BITS; i++) begin
         if (one_hot[i]) begin
            idx = idx | 6'(i);
         end
      end
      return idx;
   endfunction

   // byte-wise counts, then a sum over the eight bytes
   function automatic logic [6:0] pop_count(logic [63:0] v);
      logic [3:0] part [8];
      logic [6:0] sum;
      sum = '0;
      for (int b = 0; b < 8; b++) begin
         part[b] = '0;
         for (int k = 0; k < 8; k++) begin
            part[b] = part[b] + 4'(v[8*b+k]);
         end
      end
      for (int b = 0; b < 8; b++) begin
         sum = sum + 7'(part[b]);
      end
      return sum;
   endfunction

endpackage

@@ rtl/bqu_compute.sv @@
// operation logic of the bitmap query unit: one request beat to one response beat
// depends on bqu_pkg
module bqu_compute (
   input  bqu_pkg::req_beat_type req_beat,
   input  logic [6:0]            map_size,
   output bqu_pkg::rsp_beat_type rsp_beat
);

   logic [6:0]                   size;
   logic [bqu_pkg::MAP_BITS-1:0] size_mask;
   logic [bqu_pkg::MAP_BITS-1:0] map_a;
   logic [bqu_pkg::MAP_BITS-1:0] map_b;
   logic [bqu_pkg::MAP_BITS-1:0] map_ab;
   logic [bqu_pkg::MAP_BITS-1:0] srch;
   logic [bqu_pkg::MAP_BITS-1:0] above;
   logic [bqu_pkg::MAP_BITS-1:0] below;
   logic [bqu_pkg::MAP_BITS-1:0] first_src;
   logic                         start_ok;
   logic                         next_hit;
   logic [5:0]                   next_idx;
   bqu_pkg::op_type              op;

   assign op   = bqu_pkg::op_type'(req_beat.op);
   assign size = (map_size > 7'(bqu_pkg::MAP_BITS)) ? 7'(bqu_pkg::MAP_BITS) : map_size;

   // size saturates at the map width, so bit 6 means all positions
   assign size_mask = size[6] ? '1 :
                      ((bqu_pkg::MAP_BITS'(1) << size[5:0]) - bqu_pkg::MAP_BITS'(1));

   assign map_a    = req_beat.first_map & size_mask;
   assign map_b    = req_beat.second_map & size_mask;
   assign map_ab   = map_a & map_b;
   assign start_ok = {1'b0, req_beat.start_index} < size;

   // circular search: positions above start first, then wrap to those below
   assign srch  = (op == bqu_pkg::OP_NEXT) ? map_a : map_ab;
   assign above = srch & ~((bqu_pkg::MAP_BITS'(2) << req_beat.start_index)
                           - bqu_pkg::MAP_BITS'(1));
   assign below = srch & ((bqu_pkg::MAP_BITS'(1) << req_beat.start_index)
                          - bqu_pkg::MAP_BITS'(1));
   assign next_hit = start_ok && ((above != '0) || (below != '0));
   assign next_idx = (above != '0) ? bqu_pkg::low_index(above) : bqu_pkg::low_index(below);

   assign first_src = (op == bqu_pkg::OP_FIRST) ? map_a : map_ab;

   always_comb begin
      rsp_beat = '0;
      case (op)
         bqu_pkg::OP_NEXT, bqu_pkg::OP_NEXT_AND: begin
            rsp_beat.found       = next_hit;
            rsp_beat.found_index = next_hit ? next_idx : 6'd0;
         end
         bqu_pkg::OP_FIRST, bqu_pkg::OP_FIRST_AND: begin
            rsp_beat.found       = (first_src != '0);
            rsp_beat.found_index = bqu_pkg::low_index(first_src);
         end
         bqu_pkg::OP_TEST: begin
            rsp_beat.result_flag = start_ok & map_a[req_beat.start_index];
         end
         bqu_pkg::OP_WEIGHT: begin
            rsp_beat.bit_count = bqu_pkg::pop_count(map_a);
         end
         bqu_pkg::OP_AND: begin
            rsp_beat.result_map  = map_ab;
            rsp_beat.result_flag = 1'b1;
         end
         bqu_pkg::OP_OR: begin
            rsp_beat.result_map  = map_a | map_b;
            rsp_beat.result_flag = 1'b1;
         end
         bqu_pkg::OP_EQUAL: begin
            rsp_beat.result_flag = (map_a == map_b);
         end
         bqu_pkg::OP_SUBSET: begin
            rsp_beat.result_flag = ((map_a & ~map_b) == '0);
         end
         default: begin
            rsp_beat = '0;
         end
      endcase
   end

endmodule

@@ rtl/bqu_rsp_reg.sv @@
// response register of the bitmap query unit with valid/ready handshake
// depends on bqu_pkg
module bqu_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bqu_pkg::rsp_beat_type in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bqu_pkg::rsp_beat_type out_beat
);

   logic                  valid_ff;
   logic                  valid_in;
   bqu_pkg::rsp_beat_type beat_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = (in_valid && in_ready) ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

endmodule

@@ rtl/bitmap_query_unit.sv @@
// Bitmap query unit: each request is registered, the operation is evaluated combinationally
// and the answer waits in a response register. A response is valid once its request has
// passed the request register and been captured in the response register, and
// a new request is taken every cycle; the only stall comes from the response side holding
// back rsp_ready. map_size (reset 64) is written on the csr channel, which is always ready,
// and should only change while no request is in flight.
// top level; depends on bqu_pkg, bqu_compute, bqu_rsp_reg, bitmap_query_unit_defines.svh
`include "bitmap_query_unit_defines.svh"

module bitmap_query_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_type,
   input  logic [63:0] req_first_map,
   input  logic [63:0] req_second_map,
   input  logic [5:0]  req_start_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [5:0]  rsp_found_index,
   output logic [63:0] rsp_result_map,
   output logic [6:0]  rsp_bit_count,
   output logic        rsp_result_flag
);

   logic [6:0]            map_size_ff;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   bqu_pkg::req_beat_type s1_beat_ff;
   bqu_pkg::rsp_beat_type calc_beat;
   bqu_pkg::rsp_beat_type out_beat;
   logic                  rr_ready;
   logic                  req_fire;

   assign csr_ready   = 1'b1;
   assign req_ready   = !s1_valid_ff || rr_ready;
   assign req_fire    = req_valid && req_ready;
   assign s1_valid_in = req_fire ? 1'b1 : (rr_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff <= 7'(bqu_pkg::MAP_BITS);
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            map_size_ff <= csr_data;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_beat_ff <= '{op: req_type, first_map: req_first_map,
                         second_map: req_second_map, start_index: req_start_index};
      end
   end

   bqu_compute u_compute (
      .req_beat (s1_beat_ff),
      .map_size (map_size_ff),
      .rsp_beat (calc_beat)
   );

   bqu_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (rr_ready),
      .in_beat   (calc_beat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (out_beat)
   );

   assign rsp_found       = out_beat.found;
   assign rsp_found_index = out_beat.found_index;
   assign rsp_result_map  = out_beat.result_map;
   assign rsp_bit_count   = out_beat.bit_count;
   assign rsp_result_flag = out_beat.result_flag;

   `BQU_ASSERT_RST(a_req_loads_stage, clock, reset, req_fire |=> s1_valid_ff, "accepted beat lost before compute stage")
   `BQU_ASSERT_RST(a_backpressure, clock, reset, (rsp_valid && !rsp_ready && s1_valid_ff) |-> !req_ready, "request taken while pipeline full")
   `BQU_ASSERT_RST(a_found_only_search, clock, reset, (rsp_valid && rsp_found) |-> (rsp_bit_count == 7'd0 && rsp_result_map == '0 && !rsp_result_flag), "found set on a non-search response")
   `BQU_ASSERT_RST(a_found_in_range, clock, reset, (rsp_valid && rsp_found) |-> ({1'b0, rsp_found_index} < map_size_ff), "found index outside map size")
   `BQU_ASSERT(a_reset_clears, clock, (!reset && $past(reset)) |-> (!s1_valid_ff && !rsp_valid), "valid state not cleared by reset")

endmodule
